// ----- src/lob_pkg.sv -----
// Shared types and constants of the limit order book.
// Depends on nothing; lob_ctrl, lob_datapath, limit_order_book and the testbench import it.
`timescale 1ns / 1ps

package lob_pkg;

   localparam int DEF_MAX_ORDERS          = 1024;
   localparam int DEF_MAX_LEVELS_PER_SIDE = 64;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_DELETE  = 2'd1,
      CMD_EXECUTE = 2'd2,
      CMD_REPLACE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RSP_OK        = 2'd0,
      RSP_NOT_FOUND = 2'd1,
      RSP_DUPLICATE = 2'd2,
      RSP_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_OSCAN,
      S_LSCAN,
      S_DECIDE,
      S_APPLY1,
      S_APPLY2,
      S_SSCAN,
      S_RESP
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic oscan;
      logic lscan;
      logic decide;
      logic apply1;
      logic apply2;
      logic sscan;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
   } sts_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic        side;
      logic [31:0] price;
      logic [31:0] shares;
   } ord_entry_type;

endpackage

// ----- src/lob_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module lob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ----- src/lob_ctrl.sv -----
// Command sequencer of the limit order book.
// Depends on lob_pkg.
`timescale 1ns / 1ps

module lob_ctrl
   import lob_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   input  sts_type sts,
   output ctl_type ctl
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (sts.scan_done) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = S_OSCAN;
         S_OSCAN:  if (sts.scan_done) state_in = S_LSCAN;
         S_LSCAN:  if (sts.scan_done) state_in = S_DECIDE;
         S_DECIDE: state_in = S_APPLY1;
         S_APPLY1: state_in = S_APPLY2;
         S_APPLY2: state_in = S_SSCAN;
         S_SSCAN:  if (sts.scan_done) state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      ctl        = '0;
      busy       = (state_ff != S_IDLE);
      rsp_valid  = (state_ff == S_RESP);
      ctl.clear  = (state_ff == S_CLEAR);
      ctl.load   = (state_ff == S_IDLE) && start;
      ctl.oscan  = (state_ff == S_OSCAN);
      ctl.lscan  = (state_ff == S_LSCAN);
      ctl.decide = (state_ff == S_DECIDE);
      ctl.apply1 = (state_ff == S_APPLY1);
      ctl.apply2 = (state_ff == S_APPLY2);
      ctl.sscan  = (state_ff == S_SSCAN);
   end

endmodule

// ----- src/lob_datapath.sv -----
// Order table, level table, scan logic and result registers of the book.
// Depends on lob_pkg and lob_ram.
`timescale 1ns / 1ps

module lob_datapath
   import lob_pkg::*;
#(
   parameter int MAX_ORDERS          = DEF_MAX_ORDERS,
   parameter int MAX_LEVELS_PER_SIDE = DEF_MAX_LEVELS_PER_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_order_reference,
   input  logic [63:0] req_new_reference,
   input  logic        req_is_buy,
   input  logic [31:0] req_share_count,
   input  logic [31:0] req_limit_price,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_best_bid,
   output logic        rsp_bid_present,
   output logic [31:0] rsp_best_ask,
   output logic        rsp_ask_present,
   output logic [31:0] rsp_spread,
   output logic [6:0]  rsp_bid_level_count,
   output logic [6:0]  rsp_ask_level_count,
   output logic [31:0] rsp_touched_level_volume,
   output logic [31:0] rsp_bid_total_volume,
   output logic [31:0] rsp_ask_total_volume
);

   localparam int LSLOTS = 2 * MAX_LEVELS_PER_SIDE;
   localparam int OIW    = $clog2(MAX_ORDERS);
   localparam int LIW    = $clog2(LSLOTS);
   localparam int CLR_N  = (MAX_ORDERS > LSLOTS) ? MAX_ORDERS : LSLOTS;
   localparam int CW     = $clog2(CLR_N + 1);
   localparam int OCW    = $clog2(MAX_ORDERS + 1);
   localparam int SCW    = $clog2(LSLOTS + 1);

   typedef struct packed {
      logic            valid;
      logic            side;
      logic [31:0]     price;
      logic [31:0]     volume;
      logic [OCW-1:0]  count;
   } lvl_entry_type;

   // captured command
   cmd_type     cmd_ff;
   logic [63:0] ref_ff, nref_ff;
   logic        buy_ff;
   logic [31:0] sh_ff, price_ff;

   // scan sequencing
   logic [CW-1:0] cnt_ff, cnt_in, pidx_ff, scan_n;
   logic          pv_ff, pv_in, scanning, done;

   // order scan results
   logic           o_found_ff, d_found_ff, f_found_ff;
   logic [OIW-1:0] o_idx_ff, d_idx_ff, f_idx_ff;
   logic           o_side_ff;
   logic [31:0]    o_price_ff, o_shares_ff;

   // level scan results
   logic           ol_found_ff, nl_found_ff, lf_found_ff;
   logic [LIW-1:0] ol_idx_ff, nl_idx_ff, lf_idx_ff;
   logic [31:0]    ol_vol_ff, nl_vol_ff;
   logic [OCW-1:0] ol_cnt_ff, nl_cnt_ff;
   logic [SCW-1:0] side_cnt_ff;
   logic           scan_side;

   // decision
   status_type     status_ff;
   logic           op_remove_ff, op_take_ff, op_insert_ff, ow_en_ff;
   logic [OIW-1:0] ow_idx_ff;
   ord_entry_type  ow_data_ff;

   // level update
   logic           s1_done_ff, s1_gone_ff;
   logic [31:0]    s1_vol_ff;
   logic [OCW-1:0] s1_cnt_ff;
   logic [31:0]    touched_ff;

   // summary
   logic [31:0]    bb_ff, ba_ff, bsum_ff, asum_ff;
   logic           hb_ff, ha_ff;
   logic [SCW-1:0] nb_ff, na_ff;

   // memories
   logic           o_we, l_we;
   logic [OIW-1:0] o_waddr;
   logic [LIW-1:0] l_waddr;
   ord_entry_type  o_wdata, o_rdata;
   lvl_entry_type  l_wdata, l_rdata;

   lob_ram #(.WIDTH($bits(ord_entry_type)), .DEPTH(MAX_ORDERS)) u_ord_ram (
      .clock (clock),
      .we    (o_we),
      .waddr (o_waddr),
      .wdata (o_wdata),
      .raddr (cnt_ff[OIW-1:0]),
      .rdata (o_rdata)
   );

   lob_ram #(.WIDTH($bits(lvl_entry_type)), .DEPTH(LSLOTS)) u_lvl_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (l_wdata),
      .raddr (cnt_ff[LIW-1:0]),
      .rdata (l_rdata)
   );

   // ---------------- scan counter ----------------
   always_comb begin
      scanning = ctl.clear | ctl.oscan | ctl.lscan | ctl.sscan;
      if (ctl.oscan) begin
         scan_n = CW'(MAX_ORDERS);
      end else if (ctl.clear) begin
         scan_n = CW'(CLR_N);
      end else begin
         scan_n = CW'(LSLOTS);
      end
      done   = scanning && (cnt_ff == scan_n) && !pv_ff;
      cnt_in = '0;
      if (scanning && !done && (cnt_ff != scan_n)) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (scanning && !done) begin
         cnt_in = cnt_ff;
      end
      pv_in = (ctl.oscan | ctl.lscan | ctl.sscan) && (cnt_ff != scan_n);
   end

   assign sts.scan_done = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pv_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         pv_ff  <= pv_in;
      end
      pidx_ff <= cnt_ff;
   end

   // ---------------- level update arithmetic ----------------
   logic [31:0]    amt, s1_vol, base_vol, ins_vol;
   logic [OCW-1:0] s1_cnt, base_cnt;
   logic           s1_gone, s1_en, same_lvl, use_nl;
   logic [LIW-1:0] tgt;
   logic [32:0]    ins_sum;

   always_comb begin
      amt     = op_remove_ff ? o_shares_ff : sh_ff;
      s1_vol  = (ol_vol_ff >= amt) ? (ol_vol_ff - amt) : '0;
      s1_cnt  = ol_cnt_ff;
      if (op_remove_ff && (ol_cnt_ff != '0)) begin
         s1_cnt = ol_cnt_ff - OCW'(1);
      end
      s1_gone = op_remove_ff && (s1_cnt == '0);
      s1_en   = (op_remove_ff | op_take_ff) && ol_found_ff;

      same_lvl = nl_found_ff && s1_done_ff && (nl_idx_ff == ol_idx_ff);
      use_nl   = nl_found_ff && !(same_lvl && s1_gone_ff);
      if (use_nl) begin
         tgt      = nl_idx_ff;
         base_vol = same_lvl ? s1_vol_ff : nl_vol_ff;
         base_cnt = same_lvl ? s1_cnt_ff : nl_cnt_ff;
      end else begin
         // a level freed by this command's removal may sit below the free slot found
         if (s1_done_ff && s1_gone_ff && (!lf_found_ff || (ol_idx_ff < lf_idx_ff))) begin
            tgt = ol_idx_ff;
         end else begin
            tgt = lf_idx_ff;
         end
         base_vol = '0;
         base_cnt = '0;
      end
      ins_sum = {1'b0, base_vol} + {1'b0, sh_ff};
      ins_vol = ins_sum[32] ? '1 : ins_sum[31:0];
   end

   // ---------------- memory write ports ----------------
   always_comb begin
      o_we    = 1'b0;
      o_waddr = ow_idx_ff;
      o_wdata = ow_data_ff;
      l_we    = 1'b0;
      l_waddr = tgt;
      l_wdata = '0;
      if (ctl.clear) begin
         o_we    = !done && (cnt_ff < CW'(MAX_ORDERS));
         o_waddr = cnt_ff[OIW-1:0];
         o_wdata = '0;
         l_we    = !done && (cnt_ff < CW'(LSLOTS));
         l_waddr = cnt_ff[LIW-1:0];
      end else if (ctl.apply1) begin
         o_we          = ow_en_ff;
         l_we          = s1_en;
         l_waddr       = ol_idx_ff;
         l_wdata.valid = !s1_gone;
         l_wdata.side  = scan_side;
         l_wdata.price = o_price_ff;
         l_wdata.volume = s1_vol;
         l_wdata.count = s1_cnt;
      end else if (ctl.apply2) begin
         l_we           = op_insert_ff;
         l_wdata.valid  = 1'b1;
         l_wdata.side   = scan_side;
         l_wdata.price  = price_ff;
         l_wdata.volume = ins_vol;
         l_wdata.count  = base_cnt + OCW'(1);
      end
   end

   assign scan_side = (cmd_ff == CMD_ADD) ? buy_ff : o_side_ff;

   // ---------------- decision ----------------
   logic           rep_gone, rep_stays;
   logic [SCW-1:0] rep_after;
   status_type     dec_status;
   logic           dec_remove, dec_take, dec_insert, dec_wen;
   logic [OIW-1:0] dec_widx;
   ord_entry_type  dec_wdata;

   always_comb begin
      rep_gone  = ol_found_ff && (ol_cnt_ff <= OCW'(1));
      rep_stays = nl_found_ff && !((nl_idx_ff == ol_idx_ff) && rep_gone);
      rep_after = side_cnt_ff - SCW'(rep_gone);

      dec_status = RSP_OK;
      dec_remove = 1'b0;
      dec_take   = 1'b0;
      dec_insert = 1'b0;
      dec_wen    = 1'b0;
      dec_widx   = o_idx_ff;
      dec_wdata  = '0;
      case (cmd_ff)
         CMD_ADD: begin
            if (o_found_ff) begin
               dec_status = RSP_DUPLICATE;
            end else if (!f_found_ff) begin
               dec_status = RSP_FULL;
            end else if (!nl_found_ff && (side_cnt_ff >= SCW'(MAX_LEVELS_PER_SIDE))) begin
               dec_status = RSP_FULL;
            end else begin
               dec_insert = 1'b1;
               dec_wen    = 1'b1;
               dec_widx   = f_idx_ff;
               dec_wdata  = '{valid: 1'b1, key: ref_ff, side: buy_ff,
                              price: price_ff, shares: sh_ff};
            end
         end
         CMD_DELETE: begin
            if (!o_found_ff) begin
               dec_status = RSP_NOT_FOUND;
            end else begin
               dec_remove = 1'b1;
               dec_wen    = 1'b1;
            end
         end
         CMD_EXECUTE: begin
            if (!o_found_ff) begin
               dec_status = RSP_NOT_FOUND;
            end else if (sh_ff >= o_shares_ff) begin
               dec_remove = 1'b1;
               dec_wen    = 1'b1;
            end else begin
               dec_take  = 1'b1;
               dec_wen   = 1'b1;
               dec_wdata = '{valid: 1'b1, key: ref_ff, side: o_side_ff,
                             price: o_price_ff, shares: o_shares_ff - sh_ff};
            end
         end
         CMD_REPLACE: begin
            if (!o_found_ff) begin
               dec_status = RSP_NOT_FOUND;
            end else if (d_found_ff && (d_idx_ff != o_idx_ff)) begin
               dec_status = RSP_DUPLICATE;
            end else if (!rep_stays && (rep_after >= SCW'(MAX_LEVELS_PER_SIDE))) begin
               dec_status = RSP_FULL;
            end else begin
               dec_remove = 1'b1;
               dec_insert = 1'b1;
               dec_wen    = 1'b1;
               dec_wdata  = '{valid: 1'b1, key: nref_ff, side: o_side_ff,
                              price: price_ff, shares: sh_ff};
            end
         end
         default: dec_status = RSP_OK;
      endcase
   end

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff      <= cmd_type'(req_command);
         ref_ff      <= req_order_reference;
         nref_ff     <= req_new_reference;
         buy_ff      <= req_is_buy;
         sh_ff       <= req_share_count;
         price_ff    <= req_limit_price;
         o_found_ff  <= 1'b0;
         d_found_ff  <= 1'b0;
         f_found_ff  <= 1'b0;
         ol_found_ff <= 1'b0;
         nl_found_ff <= 1'b0;
         lf_found_ff <= 1'b0;
         side_cnt_ff <= '0;
      end

      if (ctl.oscan && pv_ff) begin
         if (o_rdata.valid && (o_rdata.key == ref_ff) && !o_found_ff) begin
            o_found_ff  <= 1'b1;
            o_idx_ff    <= pidx_ff[OIW-1:0];
            o_side_ff   <= o_rdata.side;
            o_price_ff  <= o_rdata.price;
            o_shares_ff <= o_rdata.shares;
         end
         if (o_rdata.valid && (o_rdata.key == nref_ff) && !d_found_ff) begin
            d_found_ff <= 1'b1;
            d_idx_ff   <= pidx_ff[OIW-1:0];
         end
         if (!o_rdata.valid && !f_found_ff) begin
            f_found_ff <= 1'b1;
            f_idx_ff   <= pidx_ff[OIW-1:0];
         end
      end

      if (ctl.lscan && pv_ff) begin
         if (l_rdata.valid && (l_rdata.side == scan_side)) begin
            side_cnt_ff <= side_cnt_ff + SCW'(1);
            if ((cmd_ff != CMD_ADD) && (l_rdata.price == o_price_ff) && !ol_found_ff) begin
               ol_found_ff <= 1'b1;
               ol_idx_ff   <= pidx_ff[LIW-1:0];
               ol_vol_ff   <= l_rdata.volume;
               ol_cnt_ff   <= l_rdata.count;
            end
            if ((l_rdata.price == price_ff) && !nl_found_ff) begin
               nl_found_ff <= 1'b1;
               nl_idx_ff   <= pidx_ff[LIW-1:0];
               nl_vol_ff   <= l_rdata.volume;
               nl_cnt_ff   <= l_rdata.count;
            end
         end
         if (!l_rdata.valid && !lf_found_ff) begin
            lf_found_ff <= 1'b1;
            lf_idx_ff   <= pidx_ff[LIW-1:0];
         end
      end

      if (ctl.decide) begin
         status_ff    <= dec_status;
         op_remove_ff <= dec_remove;
         op_take_ff   <= dec_take;
         op_insert_ff <= dec_insert;
         ow_en_ff     <= dec_wen;
         ow_idx_ff    <= dec_widx;
         ow_data_ff   <= dec_wdata;
         s1_done_ff   <= 1'b0;
         s1_gone_ff   <= 1'b0;
         touched_ff   <= '0;
         bb_ff   <= '0;
         ba_ff   <= '1;
         hb_ff   <= 1'b0;
         ha_ff   <= 1'b0;
         nb_ff   <= '0;
         na_ff   <= '0;
         bsum_ff <= '0;
         asum_ff <= '0;
      end

      if (ctl.apply1 && s1_en) begin
         s1_done_ff <= 1'b1;
         s1_gone_ff <= s1_gone;
         s1_vol_ff  <= s1_vol;
         s1_cnt_ff  <= s1_cnt;
         touched_ff <= s1_gone ? '0 : s1_vol;
      end

      if (ctl.apply2 && op_insert_ff) begin
         touched_ff <= ins_vol;
      end

      if (ctl.sscan && pv_ff && l_rdata.valid) begin
         if (l_rdata.side) begin
            nb_ff <= nb_ff + SCW'(1);
            hb_ff <= 1'b1;
            if (!hb_ff || (l_rdata.price > bb_ff)) begin
               bb_ff <= l_rdata.price;
            end
            bsum_ff <= sat_add(bsum_ff, l_rdata.volume);
         end else begin
            na_ff <= na_ff + SCW'(1);
            ha_ff <= 1'b1;
            if (!ha_ff || (l_rdata.price < ba_ff)) begin
               ba_ff <= l_rdata.price;
            end
            asum_ff <= sat_add(asum_ff, l_rdata.volume);
         end
      end
   end

   // ---------------- result ----------------
   always_comb begin
      rsp_status               = status_ff;
      rsp_best_bid             = bb_ff;
      rsp_bid_present          = hb_ff;
      rsp_best_ask             = ba_ff;
      rsp_ask_present          = ha_ff;
      rsp_bid_level_count      = 7'(nb_ff);
      rsp_ask_level_count      = 7'(na_ff);
      rsp_touched_level_volume = touched_ff;
      rsp_bid_total_volume     = bsum_ff;
      rsp_ask_total_volume     = asum_ff;
      if (!hb_ff || !ha_ff) begin
         rsp_spread = '1;
      end else if (ba_ff >= bb_ff) begin
         rsp_spread = ba_ff - bb_ff;
      end else begin
         rsp_spread = '0;
      end
   end

endmodule

// ----- src/limit_order_book.sv -----
// Limit order book for one symbol: one command per item, one result per item.
// Each item runs a scan of the order RAM and two scans of the level RAM, one entry a
// cycle, with busy high; a new item is taken only after the last one has answered,
// and busy drops in the cycle after the strobe. Reset: a clearing pass over
// max(MAX_ORDERS, 2*MAX_LEVELS_PER_SIDE) entries runs with busy high.
// The receiver cannot stall; rsp_valid lasts one cycle.
`timescale 1ns / 1ps

module limit_order_book
   import lob_pkg::*;
#(
   parameter int MAX_ORDERS          = DEF_MAX_ORDERS,
   parameter int MAX_LEVELS_PER_SIDE = DEF_MAX_LEVELS_PER_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_order_reference,
   input  logic [63:0] req_new_reference,
   input  logic        req_is_buy,
   input  logic [31:0] req_share_count,
   input  logic [31:0] req_limit_price,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_best_bid,
   output logic        rsp_bid_present,
   output logic [31:0] rsp_best_ask,
   output logic        rsp_ask_present,
   output logic [31:0] rsp_spread,
   output logic [6:0]  rsp_bid_level_count,
   output logic [6:0]  rsp_ask_level_count,
   output logic [31:0] rsp_touched_level_volume,
   output logic [31:0] rsp_bid_total_volume,
   output logic [31:0] rsp_ask_total_volume
);

   ctl_type ctl;
   sts_type sts;

   lob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   lob_datapath #(
      .MAX_ORDERS          (MAX_ORDERS),
      .MAX_LEVELS_PER_SIDE (MAX_LEVELS_PER_SIDE)
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .ctl                      (ctl),
      .sts                      (sts),
      .req_command              (req_command),
      .req_order_reference      (req_order_reference),
      .req_new_reference        (req_new_reference),
      .req_is_buy               (req_is_buy),
      .req_share_count          (req_share_count),
      .req_limit_price          (req_limit_price),
      .rsp_status               (rsp_status),
      .rsp_best_bid             (rsp_best_bid),
      .rsp_bid_present          (rsp_bid_present),
      .rsp_best_ask             (rsp_best_ask),
      .rsp_ask_present          (rsp_ask_present),
      .rsp_spread               (rsp_spread),
      .rsp_bid_level_count      (rsp_bid_level_count),
      .rsp_ask_level_count      (rsp_ask_level_count),
      .rsp_touched_level_volume (rsp_touched_level_volume),
      .rsp_bid_total_volume     (rsp_bid_total_volume),
      .rsp_ask_total_volume     (rsp_ask_total_volume)
   );

endmodule

// ----- src/lob_checker.sv -----
// Port-level checks for the limit order book, bound to the top level.
// Depends on limit_order_book.
`timescale 1ns / 1ps

module lob_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_best_bid,
   input logic        rsp_bid_present,
   input logic        rsp_ask_present,
   input logic [31:0] rsp_spread,
   input logic [6:0]  rsp_bid_level_count
);

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a busy window");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_empty_bids: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bid_present) |-> (rsp_best_bid == 32'd0 &&
                                           rsp_bid_level_count == 7'd0))
      else $error("empty bid side shows a price or levels");

   a_spread_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_bid_present || !rsp_ask_present)) |-> (rsp_spread == 32'hFFFF_FFFF))
      else $error("spread not all ones with an empty side");

endmodule

bind limit_order_book lob_checker u_lob_checker (.*);

// ----- tb/tb_limit_order_book.sv -----
// Self-checking testbench for limit_order_book: directed and random commands,
// each result checked field by field against an in-bench model of the book.
// Depends on lob_pkg and the limit_order_book RTL.
`timescale 1ns / 1ps

module tb_limit_order_book;
   import lob_pkg::*;

   localparam int NORD = DEF_MAX_ORDERS;
   localparam int NLVL = DEF_MAX_LEVELS_PER_SIDE;
   localparam int NSLOT = 2 * NLVL;
   localparam logic [31:0] ONES = 32'hFFFF_FFFF;
   localparam int SETTLE = 1400;
   localparam longint LIMIT = 12_000_000;

   typedef struct {
      cmd_type     cmd;
      logic [63:0] oref;
      logic [63:0] nref;
      logic        buy;
      logic [31:0] shares;
      logic [31:0] price;
      bit          drain;   // hold until the book has answered everything
      bit          calm;    // no idle gap after this item
   } cmd_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] bid;
      logic        bid_ok;
      logic [31:0] ask;
      logic        ask_ok;
      logic [31:0] spread;
      logic [6:0]  nbid;
      logic [6:0]  nask;
      logic [31:0] touched;
      logic [31:0] bid_vol;
      logic [31:0] ask_vol;
   } book_view_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [63:0] req_order_reference = '0;
   logic [63:0] req_new_reference = '0;
   logic        req_is_buy = 0;
   logic [31:0] req_share_count = '0;
   logic [31:0] req_limit_price = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_best_bid, rsp_best_ask, rsp_spread, rsp_touched_level_volume;
   logic        rsp_bid_present, rsp_ask_present;
   logic [6:0]  rsp_bid_level_count, rsp_ask_level_count;
   logic [31:0] rsp_bid_total_volume, rsp_ask_total_volume;

   limit_order_book DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // book model state
   bit          ord_live [NORD];
   logic [63:0] ord_ref [NORD];
   logic        ord_buy [NORD];
   logic [31:0] ord_px [NORD];
   logic [31:0] ord_qty [NORD];
   bit          lvl_live [NSLOT];
   logic        lvl_buy [NSLOT];
   logic [31:0] lvl_px [NSLOT];
   logic [31:0] lvl_vol [NSLOT];
   int          lvl_orders [NSLOT];

   cmd_item_type  pending_cmds[$];
   book_view_type awaited_views[$];
   int            mismatches = 0;
   int            results_seen = 0;
   int            rejects_seen = 0;
   longint        cycles = 0;
   int            gap = 0;
   cmd_item_type  cur;

   function automatic int find_order(logic [63:0] r);
      for (int i = 0; i < NORD; i++)
         if (ord_live[i] && ord_ref[i] == r) return i;
      return -1;
   endfunction

   function automatic int find_level(logic s, logic [31:0] p);
      for (int i = 0; i < NSLOT; i++)
         if (lvl_live[i] && lvl_buy[i] == s && lvl_px[i] == p) return i;
      return -1;
   endfunction

   function automatic int levels_on(logic s);
      int n = 0;
      for (int i = 0; i < NSLOT; i++)
         if (lvl_live[i] && lvl_buy[i] == s) n++;
      return n;
   endfunction

   function automatic logic [31:0] pull_order(int o);
      logic [31:0] left = 0;
      int l = find_level(ord_buy[o], ord_px[o]);
      if (l >= 0) begin
         lvl_vol[l] = (lvl_vol[l] >= ord_qty[o]) ? lvl_vol[l] - ord_qty[o] : 0;
         if (lvl_orders[l] > 0) lvl_orders[l]--;
         if (lvl_orders[l] == 0) lvl_live[l] = 0;
         else left = lvl_vol[l];
      end
      ord_live[o] = 0;
      return left;
   endfunction

   function automatic logic [31:0] place_order(int o, logic [63:0] r, logic s,
                                               logic [31:0] p, logic [31:0] q);
      int l = find_level(s, p);
      ord_live[o] = 1; ord_ref[o] = r; ord_buy[o] = s; ord_px[o] = p; ord_qty[o] = q;
      if (l < 0) begin
         for (int i = 0; i < NSLOT; i++)
            if (!lvl_live[i]) begin
               l = i;
               break;
            end
         if (l < 0) return 0;
         lvl_live[l] = 1; lvl_buy[l] = s; lvl_px[l] = p; lvl_vol[l] = 0; lvl_orders[l] = 0;
      end
      lvl_vol[l] = (ONES - lvl_vol[l] >= q) ? lvl_vol[l] + q : ONES;
      lvl_orders[l]++;
      return lvl_vol[l];
   endfunction

   function automatic book_view_type apply_command(cmd_item_type c);
      book_view_type v;
      int o, l, d, ol, nl, free_slot;
      bit gone, stays;
      int after;
      v.status = RSP_OK;
      v.touched = 0;
      case (c.cmd)
         CMD_ADD: begin
            free_slot = -1;
            for (int i = 0; i < NORD; i++)
               if (!ord_live[i]) begin
                  free_slot = i;
                  break;
               end
            if (find_order(c.oref) >= 0) v.status = RSP_DUPLICATE;
            else if (free_slot < 0) v.status = RSP_FULL;
            else if (find_level(c.buy, c.price) < 0 && levels_on(c.buy) >= NLVL)
               v.status = RSP_FULL;
            else v.touched = place_order(free_slot, c.oref, c.buy, c.price, c.shares);
         end
         CMD_DELETE: begin
            o = find_order(c.oref);
            if (o < 0) v.status = RSP_NOT_FOUND;
            else v.touched = pull_order(o);
         end
         CMD_EXECUTE: begin
            o = find_order(c.oref);
            if (o < 0) v.status = RSP_NOT_FOUND;
            else if (c.shares >= ord_qty[o]) v.touched = pull_order(o);
            else begin
               ord_qty[o] -= c.shares;
               l = find_level(ord_buy[o], ord_px[o]);
               if (l >= 0) begin
                  lvl_vol[l] = (lvl_vol[l] >= c.shares) ? lvl_vol[l] - c.shares : 0;
                  v.touched = lvl_vol[l];
               end
            end
         end
         default: begin
            o = find_order(c.oref);
            if (o < 0) v.status = RSP_NOT_FOUND;
            else begin
               d = find_order(c.nref);
               ol = find_level(ord_buy[o], ord_px[o]);
               gone = (ol >= 0) && lvl_orders[ol] <= 1;
               nl = find_level(ord_buy[o], c.price);
               stays = (nl >= 0) && !(nl == ol && gone);
               after = levels_on(ord_buy[o]) - (gone ? 1 : 0);
               if (d >= 0 && d != o) v.status = RSP_DUPLICATE;
               else if (!stays && after >= NLVL) v.status = RSP_FULL;
               else begin
                  void'(pull_order(o));
                  v.touched = place_order(o, c.nref, ord_buy[o], c.price, c.shares);
               end
            end
         end
      endcase
      v.bid = 0; v.ask = ONES; v.bid_ok = 0; v.ask_ok = 0;
      v.nbid = 0; v.nask = 0; v.bid_vol = 0; v.ask_vol = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (!lvl_live[i]) continue;
         if (lvl_buy[i]) begin
            v.nbid++;
            if (!v.bid_ok || lvl_px[i] > v.bid) v.bid = lvl_px[i];
            v.bid_ok = 1;
            v.bid_vol = (ONES - v.bid_vol >= lvl_vol[i]) ? v.bid_vol + lvl_vol[i] : ONES;
         end else begin
            v.nask++;
            if (!v.ask_ok || lvl_px[i] < v.ask) v.ask = lvl_px[i];
            v.ask_ok = 1;
            v.ask_vol = (ONES - v.ask_vol >= lvl_vol[i]) ? v.ask_vol + lvl_vol[i] : ONES;
         end
      end
      if (!v.bid_ok || !v.ask_ok) v.spread = ONES;
      else v.spread = (v.ask >= v.bid) ? v.ask - v.bid : 0;
      return v;
   endfunction

   // driver: one nonblocking write per signal per edge
   always @(posedge clock) begin
      bit accepted, present;
      accepted = 0;
      present = 0;
      cycles++;
      if (!reset) begin
         if (start && !busy) begin
            awaited_views = {awaited_views, apply_command(cur)};
            accepted = 1;
            if (!cur.calm && $urandom_range(3) == 0) gap = $urandom_range(13, 1);
         end
         if (start && !accepted) present = 1;
         else if (gap > 0) gap--;
         else if (pending_cmds.size() > 0 &&
                  !(pending_cmds[0].drain && (accepted || awaited_views.size() > 0))) begin
            cur = pending_cmds.pop_front();
            req_command <= cur.cmd;
            req_order_reference <= cur.oref;
            req_new_reference <= cur.nref;
            req_is_buy <= cur.buy;
            req_share_count <= cur.shares;
            req_limit_price <= cur.price;
            present = 1;
         end
         start <= present;
      end
   end

   // monitor
   always @(posedge clock) begin
      book_view_type w, a;
      if (!reset && rsp_valid) begin
         a.status = status_type'(rsp_status);
         a.bid = rsp_best_bid; a.bid_ok = rsp_bid_present;
         a.ask = rsp_best_ask; a.ask_ok = rsp_ask_present;
         a.spread = rsp_spread;
         a.nbid = rsp_bid_level_count; a.nask = rsp_ask_level_count;
         a.touched = rsp_touched_level_volume;
         a.bid_vol = rsp_bid_total_volume; a.ask_vol = rsp_ask_total_volume;
         results_seen++;
         if (awaited_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            w = awaited_views.pop_front();
            if (w.status != RSP_OK) rejects_seen++;
            if (w != a) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d mismatch:", results_seen);
                  $display(" exp st=%0d bb=%h/%b ba=%h/%b sp=%h nb=%0d na=%0d",
                           w.status, w.bid, w.bid_ok, w.ask, w.ask_ok, w.spread,
                           w.nbid, w.nask);
                  $display("     tv=%h bv=%h av=%h", w.touched, w.bid_vol, w.ask_vol);
                  $display(" got st=%0d bb=%h/%b ba=%h/%b sp=%h nb=%0d na=%0d",
                           a.status, a.bid, a.bid_ok, a.ask, a.ask_ok, a.spread,
                           a.nbid, a.nask);
                  $display("     tv=%h bv=%h av=%h", a.touched, a.bid_vol, a.ask_vol);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("timeout with %0d results outstanding", awaited_views.size());
         $display("tb_limit_order_book failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand_ref();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_cmd(cmd_type c, logic [63:0] r, logic [63:0] n, logic b,
                            logic [31:0] q, logic [31:0] p, bit hold = 0, bit calm = 0);
      cmd_item_type it;
      it.cmd = c; it.oref = r; it.nref = n; it.buy = b;
      it.shares = q; it.price = p; it.drain = hold; it.calm = calm;
      pending_cmds = {pending_cmds, it};
   endtask

   function automatic logic [31:0] rand_price();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? ONES - $urandom_range(3) : $urandom_range(3);
         default: return 32'd100_0000 + 100 * $urandom_range(12);
      endcase
   endfunction

   function automatic logic [31:0] rand_qty();
      case ($urandom_range(9))
         0: return $urandom;
         1: return ONES;
         2: return 0;
         default: return $urandom_range(500, 1);
      endcase
   endfunction

   initial begin
      logic [63:0] live_refs[$];
      logic [63:0] r, n;
      int k, total;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: extremes, each command and the reject cases
      queue_cmd(CMD_ADD, 64'd0, 64'd0, 1, 32'd0, 32'd0);
      queue_cmd(CMD_ADD, '1, '1, 0, ONES, ONES);
      queue_cmd(CMD_ADD, 64'd5, 64'd0, 0, 32'd10, ONES);          // level volume saturates
      queue_cmd(CMD_ADD, 64'd7, 64'd0, 1, ONES, 32'd1);           // bid total reaches all ones
      queue_cmd(CMD_ADD, '1, 64'd0, 1, 32'd3, 32'd9);             // duplicate reference
      queue_cmd(CMD_DELETE, 64'h1234, 64'd0, 0, 32'd0, 32'd0);    // unknown reference
      queue_cmd(CMD_EXECUTE, 64'h1234, 64'd0, 0, 32'd1, 32'd0);
      queue_cmd(CMD_REPLACE, 64'h1234, 64'd9, 0, 32'd1, 32'd0);
      queue_cmd(CMD_EXECUTE, 64'd5, 64'd0, 0, 32'd4, 32'd0);      // partial
      queue_cmd(CMD_EXECUTE, 64'd5, 64'd0, 0, ONES, 32'd0);       // full
      queue_cmd(CMD_ADD, 64'd8, 64'd0, 0, 32'd50, 32'd0);         // ask below bid: crossed
      queue_cmd(CMD_REPLACE, 64'd8, 64'd8, 0, 32'd60, 32'd2);     // same reference
      queue_cmd(CMD_REPLACE, 64'd8, 64'd7, 0, 32'd60, 32'd2);     // new ref live elsewhere
      queue_cmd(CMD_REPLACE, 64'd8, 64'hAA, 1, 32'd0, ONES, 1);   // side stays ask
      queue_cmd(CMD_EXECUTE, 64'd0, 64'd0, 1, 32'd0, 32'd0);      // zero vs zero: removes
      queue_cmd(CMD_DELETE, '1, 64'd0, 0, 32'd0, 32'd0);
      queue_cmd(CMD_DELETE, 64'd7, 64'd0, 0, 32'd0, 32'd0);
      queue_cmd(CMD_DELETE, 64'hAA, 64'd0, 0, 32'd0, 32'd0);
      // fill the bid side to its level limit, then ask for one more level
      for (int i = 0; i < NLVL; i++)
         queue_cmd(CMD_ADD, 64'h100 + i, 64'd0, 1, 32'd1, 32'd1000 + i, 0, 1);
      queue_cmd(CMD_ADD, 64'h200, 64'd0, 1, 32'd1, 32'd5);
      queue_cmd(CMD_REPLACE, 64'h100, 64'h300, 1, 32'd1, 32'd1001);  // joins live level
      queue_cmd(CMD_REPLACE, 64'h101, 64'h301, 1, 32'd1, 32'd7);     // needs a level: full
      queue_cmd(CMD_REPLACE, 64'h102, 64'h302, 1, 32'd1, 32'd7);     // own level goes: ok
      queue_cmd(CMD_DELETE, 64'h300, 64'd0, 0, 32'd0, 32'd0);
      queue_cmd(CMD_DELETE, 64'h302, 64'd0, 0, 32'd0, 32'd0);
      for (int i = 1; i < NLVL; i++)
         if (i != 2) queue_cmd(CMD_DELETE, 64'h100 + i, 64'd0, 0, 32'd0, 32'd0, 0, 1);

      // random: mostly commands on live references
      total = 350;
      for (int i = 0; i < total; i++) begin
         k = $urandom_range(99);
         r = (live_refs.size() > 0 && $urandom_range(9) != 0)
             ? live_refs[$urandom_range(live_refs.size() - 1)] : rand_ref();
         if (k < 40 || live_refs.size() == 0) begin
            if ($urandom_range(19) != 0) r = rand_ref();
            live_refs = {live_refs, r};
            queue_cmd(CMD_ADD, r, rand_ref(), $urandom_range(1), rand_qty(), rand_price(),
                      i == total / 2, i >= total - 60);
         end else if (k < 60) begin
            queue_cmd(CMD_DELETE, r, rand_ref(), $urandom_range(1), rand_qty(), rand_price(),
                      0, i >= total - 60);
         end else if (k < 80) begin
            queue_cmd(CMD_EXECUTE, r, rand_ref(), $urandom_range(1),
                      $urandom_range(1) ? rand_qty() : $urandom_range(3), rand_price(),
                      0, i >= total - 60);
         end else begin
            case ($urandom_range(3))
               0: n = r;
               1: n = live_refs[$urandom_range(live_refs.size() - 1)];
               default: n = rand_ref();
            endcase
            live_refs = {live_refs, n};
            queue_cmd(CMD_REPLACE, r, n, $urandom_range(1), rand_qty(), rand_price(),
                      0, i >= total - 60);
         end
      end

      wait (pending_cmds.size() == 0 && !start && awaited_views.size() == 0);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d results (%0d rejected) over directed and random",
               results_seen, rejects_seen);
      $display("commands; mismatches: %0d", mismatches);
      if (mismatches == 0 && awaited_views.size() == 0)
         $display("tb_limit_order_book passed");
      else
         $display("tb_limit_order_book failed");
      $finish;
   end

endmodule
